// ----- sv/lhsr_pkg.sv -----
// Shared types and constants for the line head string remover.
`timescale 1ns / 1ps
package lhsr_pkg;

    localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

    localparam int unsigned APB_ADDR_W = 5;
    localparam int unsigned APB_DATA_W = 64;
    localparam int unsigned TLEN_W     = 5;

    localparam logic [1:0] REG_TARGET_LENGTH = 2'd0;
    localparam logic [1:0] REG_TARGET_LOW    = 2'd1;
    localparam logic [1:0] REG_TARGET_HIGH   = 2'd2;

    typedef struct packed {
        logic wr_en;
        logic shift_en;
    } lhsr_cell_ctrl_t;

endpackage

// ----- sv/lhsr_if.sv -----
// Stream interfaces for the input bytes and the filtered output bytes.
`timescale 1ns / 1ps
interface lhsr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_stream;

    modport source (output valid, output data_byte, output end_of_stream, input ready);
    modport sink (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface lhsr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;

    modport source (output valid, output out_byte, output last_of_run, input ready);
    modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface

// ----- sv/lhsr_cell.sv -----
// One cell of the head buffer: holds a byte, compares it with its target byte, shifts towards the head.
`timescale 1ns / 1ps
module lhsr_cell
    import lhsr_pkg::*;
(
    input  logic            clk,
    input  lhsr_cell_ctrl_t ctrl,
    input  logic [7:0]      data_in,
    input  logic [7:0]      target,
    input  logic [7:0]      shift_in,
    output logic [7:0]      byte_out,
    output logic            hit
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    always_comb
    begin
        byte_next = byte_reg;
        if (ctrl.wr_en)
        begin
            byte_next = data_in;
        end
        else if (ctrl.shift_en)
        begin
            byte_next = shift_in;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    // The byte being written this cycle is compared directly.
    assign hit      = ctrl.wr_en ? (data_in == target) : (byte_reg == target);
    assign byte_out = byte_reg;

endmodule

// ----- sv/line_head_string_remover.sv -----
// A passed byte is registered in the output stage and appears in the cycle after its transfer.
// A released head of n bytes leaves the head cell one byte per cycle while the output is free;
// no input is taken during that release.
// Throughput is one byte per cycle while bytes pass straight through and the output is not stalled.
// Reset sets the target length to 1 and clears the target words, the state, the fill count,
// the newline flag and the output valid; held head bytes and the output byte are not cleared.
`timescale 1ns / 1ps
module line_head_string_remover
    import lhsr_pkg::*;
#(
    parameter int unsigned MAX_TARGET = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    lhsr_in_if.sink               in_stream,
    lhsr_out_if.source            out_stream,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int unsigned CW = $clog2(MAX_TARGET + 1);

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_FLUSH = 1'b1;

    // Configuration registers.
    logic [TLEN_W-1:0]     tlen_reg;
    logic [APB_DATA_W-1:0] tlow_reg;
    logic [APB_DATA_W-1:0] thigh_reg;
    logic                  cfg_wr;
    logic [1:0]            cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = paddr[4:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tlen_reg  <= TLEN_W'(1);
            tlow_reg  <= '0;
            thigh_reg <= '0;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_TARGET_LENGTH: tlen_reg  <= pwdata[TLEN_W-1:0];
                REG_TARGET_LOW:    tlow_reg  <= pwdata;
                REG_TARGET_HIGH:   thigh_reg <= pwdata;
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_TARGET_LENGTH: prdata = {{(APB_DATA_W-TLEN_W){1'b0}}, tlen_reg};
            REG_TARGET_LOW:    prdata = tlow_reg;
            REG_TARGET_HIGH:   prdata = thigh_reg;
            default:           prdata = '0;
        endcase
    end

    // Effective target length, clamped to 1 .. MAX_TARGET.
    logic [CW-1:0] eff_len;

    always_comb
    begin
        if (tlen_reg == '0)
            eff_len = CW'(1);
        else if (32'(tlen_reg) > MAX_TARGET)
            eff_len = CW'(MAX_TARGET);
        else
            eff_len = CW'(tlen_reg);
    end

    // Control state.
    logic          state_reg;
    logic          state_next;
    logic [CW-1:0] fill_reg;
    logic [CW-1:0] fill_next;
    logic          drop_reg;
    logic          drop_next;
    logic [CW-1:0] rem_reg;
    logic [CW-1:0] rem_next;

    // Output stage.
    logic       ovalid_reg;
    logic       ovalid_next;
    logic [7:0] obyte_reg;
    logic [7:0] obyte_next;
    logic       olast_reg;
    logic       olast_next;

    logic          out_free;
    logic          in_fire;
    logic          store;
    logic          shift_step;
    logic [CW-1:0] fill_inc;
    logic          match;
    logic [7:0]    c;

    logic [7:0]    cell_byte [MAX_TARGET];
    logic [7:0]    cell_tgt  [MAX_TARGET];
    logic [MAX_TARGET-1:0] cell_hit;
    logic [MAX_TARGET-1:0] cell_pass;

    assign out_free        = !ovalid_reg || out_stream.ready;
    assign in_stream.ready = (state_reg == ST_IDLE) && out_free;
    assign in_fire         = in_stream.valid && in_stream.ready;
    assign c               = in_stream.data_byte;
    assign store           = in_fire && !in_stream.end_of_stream && (fill_reg < eff_len);
    assign shift_step      = (state_reg == ST_FLUSH) && out_free;
    assign fill_inc        = fill_reg + CW'(1);

    genvar gi;
    generate
        for (gi = 0; gi < MAX_TARGET; gi++)
        begin : g_cell
            lhsr_cell_ctrl_t ctrl;
            logic [7:0]      nbr;

            if (gi < 8)
            begin : g_lo
                assign cell_tgt[gi] = tlow_reg[8*gi +: 8];
            end
            else if (gi < 16)
            begin : g_hi
                assign cell_tgt[gi] = thigh_reg[8*(gi-8) +: 8];
            end
            else
            begin : g_zero
                assign cell_tgt[gi] = 8'h00;
            end

            // The first target-length cells form a ring, so a full release leaves
            // the head in place for a later, longer target.
            if (gi == MAX_TARGET - 1)
            begin : g_end
                assign nbr = cell_byte[0];
            end
            else
            begin : g_mid
                assign nbr = (eff_len == CW'(gi + 1)) ? cell_byte[0] : cell_byte[gi+1];
            end

            assign ctrl = {store && (fill_reg == CW'(gi)), shift_step};

            lhsr_cell u_cell (
                .clk      (clk),
                .ctrl     (ctrl),
                .data_in  (c),
                .target   (cell_tgt[gi]),
                .shift_in (nbr),
                .byte_out (cell_byte[gi]),
                .hit      (cell_hit[gi])
            );

            // Cells beyond the target length do not take part in the compare.
            assign cell_pass[gi] = cell_hit[gi] || (32'(gi) >= 32'(eff_len));
        end
    endgenerate

    assign match = &cell_pass;

    always_comb
    begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        drop_next   = drop_reg;
        rem_next    = rem_reg;
        ovalid_next = ovalid_reg && !out_stream.ready;
        obyte_next  = obyte_reg;
        olast_next  = olast_reg;

        if (in_fire)
        begin
            if (in_stream.end_of_stream)
            begin
                if ((fill_reg < eff_len) && (fill_reg != '0))
                begin
                    rem_next   = fill_reg;
                    state_next = ST_FLUSH;
                end
                fill_next = '0;
                drop_next = 1'b0;
            end
            else if (fill_reg < eff_len)
            begin
                if (fill_inc == eff_len)
                begin
                    if (!match)
                    begin
                        rem_next   = eff_len;
                        state_next = ST_FLUSH;
                    end
                    if (c == NEWLINE_BYTE)
                    begin
                        fill_next = '0;
                        drop_next = 1'b0;
                    end
                    else
                    begin
                        fill_next = fill_inc;
                        drop_next = match;
                    end
                end
                else if (c == NEWLINE_BYTE)
                begin
                    // A short line releases its head, newline included.
                    rem_next   = fill_inc;
                    state_next = ST_FLUSH;
                    fill_next  = '0;
                    drop_next  = 1'b0;
                end
                else
                begin
                    fill_next = fill_inc;
                    drop_next = 1'b0;
                end
            end
            else
            begin
                if (c == NEWLINE_BYTE)
                begin
                    fill_next = '0;
                end
                if ((c != NEWLINE_BYTE) || !drop_reg)
                begin
                    ovalid_next = 1'b1;
                    obyte_next  = c;
                    olast_next  = 1'b1;
                end
                drop_next = 1'b0;
            end
        end
        else if (shift_step)
        begin
            ovalid_next = 1'b1;
            obyte_next  = cell_byte[0];
            olast_next  = (rem_reg == CW'(1));
            rem_next    = rem_reg - CW'(1);
            if (rem_reg == CW'(1))
            begin
                state_next = ST_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            fill_reg   <= '0;
            drop_reg   <= 1'b0;
            rem_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            drop_reg   <= drop_next;
            rem_reg    <= rem_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        obyte_reg <= obyte_next;
        olast_reg <= olast_next;
    end

    assign out_stream.valid       = ovalid_reg;
    assign out_stream.out_byte    = obyte_reg;
    assign out_stream.last_of_run = olast_reg;

endmodule

// ----- sim/line_head_string_remover_test.sv -----
// Self-checking testbench for the line head string remover, with its own byte filter model.
`timescale 1ns / 1ps
module line_head_string_remover_test
    import lhsr_pkg::*;
();

    localparam int unsigned MAX_TARGET      = 16;
    localparam int unsigned PHASES          = 8;
    localparam int unsigned ITEMS_PER_PHASE = 33;
    localparam int unsigned SETTLE_CYCLES   = MAX_TARGET + 8;
    localparam int unsigned WATCHDOG_LIMIT  = 1000;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } filtered_t;

    typedef enum logic [1:0] {
        ROW_BYTE,
        ROW_END,
        ROW_WRITE
    } row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [1:0]  reg_index;
        logic [63:0] value;
        logic        typed;
        logic        yields;
        logic [7:0]  fixed_byte;
    } plan_row_t;

    localparam int unsigned PLAN_ROWS = 34;

    // Rows with typed results are only those that follow directly from the reset state.
    localparam plan_row_t DIRECTED_PLAN [PLAN_ROWS] = '{
        '{ROW_BYTE,  REG_TARGET_LENGTH, 64'h41, 1'b1, 1'b1, 8'h41},
        '{ROW_BYTE,  REG_TARGET_LENGTH, 64'h00, 1'b1, 1'b1, 8'h00},
        '{ROW_BYTE,  REG_TARGET_LENGTH, 64'h0A, 1'b1, 1'b1, 8'h0A},
        '{ROW_BYTE,  REG_TARGET_LENGTH, 64'h00, 1'b1, 1'b0, 8'h00},
        '{ROW_BYTE,  REG_TARGET_LENGTH, 64'h0A, 1'b1, 1'b0, 8'h00},
        '{ROW_BYTE,  REG_TARGET_LENGTH, 64'hFF, 1'b1, 1'b1, 8'hFF},
        '{ROW_END,   REG_TARGET_LENGTH, 64'h00, 1'b1, 1'b0, 8'h00},
        '{ROW_WRITE, REG_TARGET_LENGTH, 64'd0,  1'b0, 1'b0, 8'h00},
        '{ROW_WRITE, REG_TARGET_LOW,    64'hFF, 1'b0, 1'b0, 8'h00},
        '{ROW_BYTE,  REG_TARGET_LENGTH, 64'hFF, 1'b0, 1'b0, 8'h00},
        '{ROW_BYTE,  REG_TARGET_LENGTH, 64'h7A, 1'b0, 1'b0, 8'h00},
        '{ROW_BYTE,  REG_TARGET_LENGTH, 64'h0A, 1'b0, 1'b0, 8'h00},
        '{ROW_WRITE, REG_TARGET_LENGTH, 64'd3,  1'b0, 1'b0, 8'h00},
        '{ROW_WRITE, REG_TARGET_LOW,    64'h0A6261, 1'b0, 1'b0, 8'h00},
        '{ROW_BYTE,  REG_TARGET_LENGTH, 64'h61, 1'b0, 1'b0, 8'h00},
        '{ROW_BYTE,  REG_TARGET_LENGTH, 64'h62, 1'b0, 1'b0, 8'h00},
        '{ROW_BYTE,  REG_TARGET_LENGTH, 64'h0A, 1'b0, 1'b0, 8'h00},
        '{ROW_BYTE,  REG_TARGET_LENGTH, 64'h61, 1'b0, 1'b0, 8'h00},
        '{ROW_END,   REG_TARGET_LENGTH, 64'h00, 1'b0, 1'b0, 8'h00},
        '{ROW_BYTE,  REG_TARGET_LENGTH, 64'h61, 1'b0, 1'b0, 8'h00},
        '{ROW_BYTE,  REG_TARGET_LENGTH, 64'h62, 1'b0, 1'b0, 8'h00},
        '{ROW_BYTE,  REG_TARGET_LENGTH, 64'h63, 1'b0, 1'b0, 8'h00},
        '{ROW_END,   REG_TARGET_LENGTH, 64'h00, 1'b0, 1'b0, 8'h00},
        '{ROW_BYTE,  REG_TARGET_LENGTH, 64'h61, 1'b0, 1'b0, 8'h00},
        '{ROW_BYTE,  REG_TARGET_LENGTH, 64'h62, 1'b0, 1'b0, 8'h00},
        '{ROW_WRITE, REG_TARGET_LENGTH, 64'd1,  1'b0, 1'b0, 8'h00},
        '{ROW_BYTE,  REG_TARGET_LENGTH, 64'h63, 1'b0, 1'b0, 8'h00},
        '{ROW_BYTE,  REG_TARGET_LENGTH, 64'h0A, 1'b0, 1'b0, 8'h00},
        '{ROW_WRITE, REG_TARGET_LENGTH, 64'd31, 1'b0, 1'b0, 8'h00},
        '{ROW_WRITE, REG_TARGET_HIGH,   64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 8'h00},
        '{ROW_WRITE, REG_TARGET_LOW,    64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 8'h00},
        '{ROW_BYTE,  REG_TARGET_LENGTH, 64'h78, 1'b0, 1'b0, 8'h00},
        '{ROW_BYTE,  REG_TARGET_LENGTH, 64'h0A, 1'b0, 1'b0, 8'h00},
        '{ROW_END,   REG_TARGET_LENGTH, 64'h00, 1'b0, 1'b0, 8'h00}
    };

    logic clk;
    logic rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    lhsr_in_if  in_if ();
    lhsr_out_if out_if ();

    line_head_string_remover dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_stream  (in_if),
        .out_stream (out_if),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // Filter model: register copies and line state.
    logic [4:0]  cfg_length      = 5'd1;
    logic [63:0] cfg_target_low  = '0;
    logic [63:0] cfg_target_high = '0;
    logic [7:0]  head_held [MAX_TARGET];
    int unsigned held_count      = 0;
    bit          swallow_newline = 1'b0;

    logic [7:0]  run_bytes [$];
    filtered_t   filtered_expected [$];
    filtered_t   oldest;

    int unsigned failures     = 0;
    int unsigned quiet_cycles = 0;
    int unsigned gap_pct      = 0;
    int unsigned stall_pct    = 0;
    int unsigned items_sent   = 0;

    initial clk = 1'b0;
    always #4 clk = ~clk;

    function automatic int unsigned effective_length();
        if (cfg_length == 5'd0)
            return 1;
        if (cfg_length > MAX_TARGET)
            return MAX_TARGET;
        return cfg_length;
    endfunction

    // Works out the bytes released by one input transfer into run_bytes.
    function automatic void filter_byte(input logic [7:0] c, input logic stream_end);
        int unsigned len;
        int unsigned i;
        bit          hit;
        logic [127:0] target;
        len    = effective_length();
        target = {cfg_target_high, cfg_target_low};
        run_bytes.delete();
        if (stream_end)
        begin
            if (held_count < len)
                for (i = 0; i < held_count; i++)
                    run_bytes.push_back(head_held[i]);
            held_count      = 0;
            swallow_newline = 1'b0;
        end
        else if (held_count < len)
        begin
            head_held[held_count] = c;
            held_count++;
            if (held_count == len)
            begin
                hit = 1'b1;
                for (i = 0; i < len; i++)
                    if (head_held[i] != target[8*i +: 8])
                        hit = 1'b0;
                if (!hit)
                    for (i = 0; i < len; i++)
                        run_bytes.push_back(head_held[i]);
                if (c == NEWLINE_BYTE)
                begin
                    held_count      = 0;
                    swallow_newline = 1'b0;
                end
                else
                begin
                    swallow_newline = hit;
                end
            end
            else if (c == NEWLINE_BYTE)
            begin
                for (i = 0; i < held_count; i++)
                    run_bytes.push_back(head_held[i]);
                held_count      = 0;
                swallow_newline = 1'b0;
            end
            else
            begin
                swallow_newline = 1'b0;
            end
        end
        else
        begin
            if (c == NEWLINE_BYTE)
            begin
                if (!swallow_newline)
                    run_bytes.push_back(c);
                held_count = 0;
            end
            else
            begin
                run_bytes.push_back(c);
            end
            swallow_newline = 1'b0;
        end
    endfunction

    // Leaves the caller just after a rising edge, at the edge of the transfer.
    task automatic send_item(input logic [7:0] b, input logic stream_end,
                             input bit use_fixed = 1'b0, input bit fixed_yields = 1'b0,
                             input logic [7:0] fixed_byte = 8'h00);
        int i;
        filtered_t item;
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        begin
            in_if.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < gap_pct);
        end
        in_if.valid         <= 1'b1;
        in_if.data_byte     <= stream_end ? 8'($urandom_range(0, 255)) : b;
        in_if.end_of_stream <= stream_end;
        do
            @(negedge clk);
        while (!in_if.ready);
        filter_byte(b, stream_end);
        if (use_fixed)
        begin
            run_bytes.delete();
            if (fixed_yields)
                run_bytes.push_back(fixed_byte);
        end
        for (i = 0; i < run_bytes.size(); i++)
        begin
            item.out_byte    = run_bytes[i];
            item.last_of_run = (i == run_bytes.size() - 1);
            filtered_expected.push_back(item);
        end
        @(posedge clk);
        items_sent++;
    endtask

    task automatic wait_idle();
        while (filtered_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'({index, 3'b000});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(negedge clk);
        while (!pready);
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (index)
            REG_TARGET_LENGTH: cfg_length      = value[4:0];
            REG_TARGET_LOW:    cfg_target_low  = value;
            REG_TARGET_HIGH:   cfg_target_high = value;
            default: ;
        endcase
        @(posedge clk);
    endtask

    function automatic logic [63:0] random_target_word();
        logic [63:0] word;
        logic [7:0]  b;
        int i;
        for (i = 0; i < 8; i++)
        begin
            b = 8'($urandom_range(0, 255));
            word[8*i +: 8] = (b == NEWLINE_BYTE) ? 8'h2E : b;
        end
        return word;
    endfunction

    // Mostly lines that open with the target or a piece of it, the rest noise.
    task automatic send_line();
        int unsigned len;
        int unsigned k;
        int unsigned r;
        int unsigned n;
        int unsigned i;
        logic [127:0] target;
        len    = effective_length();
        target = {cfg_target_high, cfg_target_low};
        r      = $urandom_range(0, 99);
        if (r >= 88)
        begin
            n = $urandom_range(1, 8);
            for (i = 0; i < n; i++)
                send_item(($urandom_range(0, 7) == 0) ? NEWLINE_BYTE
                                                      : 8'($urandom_range(0, 255)),
                          ($urandom_range(0, 15) == 0));
        end
        else
        begin
            k = (r < 55) ? len : $urandom_range(0, len - 1);
            for (i = 0; i < k; i++)
                send_item(target[8*i +: 8], 1'b0);
            if (r >= 55 && r < 70)
                send_item(target[8*k +: 8] ^ 8'($urandom_range(1, 255)), 1'b0);
            if (r < 40 || (r >= 55 && r < 70))
            begin
                n = $urandom_range(0, 6);
                for (i = 0; i < n; i++)
                    send_item(8'($urandom_range(0, 255)), 1'b0);
            end
            if (r >= 80)
                send_item(8'h00, 1'b1);
            else
                send_item(NEWLINE_BYTE, 1'b0);
        end
    endtask

    always @(posedge clk)
        out_if.ready <= !(stall_pct != 0 && $urandom_range(0, 99) < stall_pct);

    // Outputs are stable at the falling edge, so a transfer seen here completes at the next rise.
    always @(negedge clk)
    begin
        if (rst_n && out_if.valid && out_if.ready)
        begin
            if (filtered_expected.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got byte %h last %b",
                         $time, out_if.out_byte, out_if.last_of_run);
                failures++;
            end
            else
            begin
                oldest = filtered_expected.pop_front();
                if (out_if.out_byte !== oldest.out_byte)
                begin
                    $display("%0t: out_byte expected %h, got %h",
                             $time, oldest.out_byte, out_if.out_byte);
                    failures++;
                end
                if (out_if.last_of_run !== oldest.last_of_run)
                begin
                    $display("%0t: last_of_run expected %b, got %b",
                             $time, oldest.last_of_run, out_if.last_of_run);
                    failures++;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n || psel || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial
    begin
        int unsigned row;
        int unsigned phase;
        int unsigned phase_start;
        int unsigned r;
        logic [4:0]  length_value;
        plan_row_t   step;

        rst_n               = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        in_if.valid         = 1'b0;
        in_if.data_byte     = 8'h00;
        in_if.end_of_stream = 1'b0;
        out_if.ready        = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (row = 0; row < PLAN_ROWS; row++)
        begin
            step = DIRECTED_PLAN[row];
            case (step.kind)
                ROW_WRITE:
                begin
                    in_if.valid <= 1'b0;
                    wait_idle();
                    write_reg(step.reg_index, step.value);
                end
                ROW_END:
                    send_item(8'h00, 1'b1, step.typed, step.yields, step.fixed_byte);
                default:
                    send_item(step.value[7:0], 1'b0, step.typed, step.yields, step.fixed_byte);
            endcase
        end

        for (phase = 0; phase < PHASES; phase++)
        begin
            // The sender holds off here until every released byte has been taken.
            in_if.valid <= 1'b0;
            wait_idle();
            gap_pct   = (phase % 4 == 1) ? 50 : (phase % 4 == 3) ? 8 : 0;
            stall_pct = (phase % 4 == 2) ? 50 : (phase % 4 == 3) ? 8 : 0;
            r = $urandom_range(0, 9);
            if (phase == 2)
                length_value = 5'd1;
            else if (phase == 4)
                length_value = 5'd0;
            else if (phase == 6)
                length_value = 5'd16;
            else if (r < 6)
                length_value = 5'($urandom_range(1, 4));
            else if (r < 9)
                length_value = 5'($urandom_range(5, 16));
            else
                length_value = 5'($urandom_range(17, 31));
            write_reg(REG_TARGET_LENGTH, {59'd0, length_value});
            write_reg(REG_TARGET_LOW, random_target_word());
            write_reg(REG_TARGET_HIGH, random_target_word());
            phase_start = items_sent;
            while (items_sent - phase_start < ITEMS_PER_PHASE)
            begin
                send_line();
            end
        end

        in_if.valid <= 1'b0;
        wait_idle();
        if (failures == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- files.f -----
sv/lhsr_pkg.sv
sv/lhsr_if.sv
sv/lhsr_cell.sv
sv/line_head_string_remover.sv
sim/line_head_string_remover_test.sv
